// ===== rtl/sgtc_pkg.sv =====
// ----------------------------------------------------------------------------
// sgtc_pkg
// Shared types, constants and helpers of the three-connectivity test.
// ----------------------------------------------------------------------------
package sgtc_pkg;

  localparam int ROW_FIELDS   = 7;
  localparam int MIN_DEGREE   = 3;
  localparam int MIN_VERTICES = 4;
  localparam int QUEUE_DEPTH  = 2;

  typedef logic [ROW_FIELDS-1:0] row_t;
  typedef logic [2:0]            count_t;

  typedef struct packed {
    count_t                n;
    row_t [ROW_FIELDS-1:0] rows;
    logic                  pre_ok;
  } item_t;

  function automatic row_t mask_of(count_t n);
    row_t m;
    for (int i = 0; i < ROW_FIELDS; i++) begin
      m[i] = (i < int'(n));
    end
    return m;
  endfunction

  function automatic logic [2:0] popcount(row_t r);
    logic [2:0] c;
    c = '0;
    for (int i = 0; i < ROW_FIELDS; i++) begin
      c = c + {2'b00, r[i]};
    end
    return c;
  endfunction

endpackage

// ===== rtl/sgtc_front.sv =====
// ----------------------------------------------------------------------------
// sgtc_front
// Classifier: clamps the vertex count, masks rows, checks minimum degree and vertex count.
// ----------------------------------------------------------------------------
module sgtc_front #(
  parameter int MAX_VERTICES = 7
) (
  input  sgtc_pkg::count_t                        vertex_count_i,
  input  sgtc_pkg::row_t [sgtc_pkg::ROW_FIELDS-1:0] rows_i,
  output sgtc_pkg::item_t                         item_o
);

  localparam int Cap = (MAX_VERTICES < sgtc_pkg::ROW_FIELDS) ? MAX_VERTICES
                                                            : sgtc_pkg::ROW_FIELDS;

  sgtc_pkg::count_t n;
  sgtc_pkg::row_t   all;
  logic             deg_ok;

  always_comb begin
    n      = (int'(vertex_count_i) > Cap) ? 3'(Cap) : vertex_count_i;
    all    = sgtc_pkg::mask_of(n);
    deg_ok = 1'b1;
    for (int x = 0; x < sgtc_pkg::ROW_FIELDS; x++) begin
      item_o.rows[x] = all[x] ? (rows_i[x] & all) : '0;
      if (all[x] &&
          int'(sgtc_pkg::popcount(item_o.rows[x] & ~(sgtc_pkg::row_t'(1) << x)))
            < sgtc_pkg::MIN_DEGREE) begin
        deg_ok = 1'b0;
      end
    end
    item_o.n      = n;
    item_o.pre_ok = deg_ok && (int'(n) >= sgtc_pkg::MIN_VERTICES);
  end

endmodule

// ===== rtl/sgtc_fifo.sv =====
// ----------------------------------------------------------------------------
// sgtc_fifo
// Short register queue between the classifier and the checker.
// ----------------------------------------------------------------------------
module sgtc_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_i,
  input  sgtc_pkg::item_t wdata_i,
  output logic            full_o,
  input  logic            rd_i,
  output sgtc_pkg::item_t rdata_o,
  output logic            empty_o
);

  localparam int Depth = sgtc_pkg::QUEUE_DEPTH;
  localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;

  sgtc_pkg::item_t mem_q [Depth];
  logic [PtrW-1:0] wp_q, rp_q;
  logic [PtrW:0]   cnt_q;
  logic            do_wr, do_rd;

  assign full_o  = (cnt_q == (PtrW+1)'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign rdata_o = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_wr) begin
        wp_q <= (wp_q == PtrW'(Depth - 1)) ? '0 : wp_q + PtrW'(1);
      end
      if (do_rd) begin
        rp_q <= (rp_q == PtrW'(Depth - 1)) ? '0 : rp_q + PtrW'(1);
      end
      cnt_q <= cnt_q + (PtrW+1)'(do_wr) - (PtrW+1)'(do_rd);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wp_q] <= wdata_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (PtrW+1)'(Depth)) else $error("queue count over depth");
  a_no_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (full_o && !do_rd) |=> (cnt_q == (PtrW+1)'(Depth)))
    else $error("full queue lost a word");
  a_ptr_eq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (empty_o || full_o) |-> (wp_q == rp_q)) else $error("pointer mismatch");

endmodule

// ===== rtl/sgtc_back.sv =====
// ----------------------------------------------------------------------------
// sgtc_back
// Checker: walks the deletion sets, one reachability closure per cycle while running.
// ----------------------------------------------------------------------------
module sgtc_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_empty_i,
  input  sgtc_pkg::item_t q_data_i,
  output logic            q_rd_o,
  output logic            empty_o,
  input  logic            pop_i,
  output logic            res_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_e;

  state_e           state_q;
  sgtc_pkg::item_t  item_q;
  sgtc_pkg::count_t x_q, y_q;
  logic             first_q, ok_q;
  logic             res_valid_q, res_q;
  sgtc_pkg::row_t   removed, alive;
  logic             conn, last_y, last_x;

  function automatic logic reach_all(sgtc_pkg::row_t [sgtc_pkg::ROW_FIELDS-1:0] rows,
                                     sgtc_pkg::row_t alive_m);
    sgtc_pkg::row_t reached, nxt;
    reached = alive_m & (~alive_m + sgtc_pkg::row_t'(1));
    for (int s = 0; s < sgtc_pkg::ROW_FIELDS - 1; s++) begin
      nxt = reached;
      for (int v = 0; v < sgtc_pkg::ROW_FIELDS; v++) begin
        if (reached[v]) begin
          nxt = nxt | (rows[v] & alive_m);
        end
      end
      reached = nxt;
    end
    return reached == alive_m;
  endfunction

  always_comb begin
    removed = first_q ? '0 : ((sgtc_pkg::row_t'(1) << x_q) | (sgtc_pkg::row_t'(1) << y_q));
    alive   = sgtc_pkg::mask_of(item_q.n) & ~removed;
    conn    = reach_all(item_q.rows, alive);
    last_y  = (y_q == item_q.n - 3'd1);
    last_x  = (x_q == item_q.n - 3'd1);
  end

  assign q_rd_o  = (state_q == ST_IDLE) && !q_empty_i;
  assign empty_o = !res_valid_q;
  assign res_o   = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      x_q         <= '0;
      y_q         <= '0;
      first_q     <= 1'b1;
      ok_q        <= 1'b0;
      res_valid_q <= 1'b0;
      res_q       <= 1'b0;
    end else begin
      if (pop_i && res_valid_q && (state_q != ST_DONE)) begin
        res_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (!q_empty_i) begin
            first_q <= 1'b1;
            x_q     <= '0;
            y_q     <= '0;
            ok_q    <= q_data_i.pre_ok;
            state_q <= q_data_i.pre_ok ? ST_RUN : ST_DONE;
          end
        end
        ST_RUN: begin
          if (!conn) begin
            ok_q    <= 1'b0;
            state_q <= ST_DONE;
          end else if (first_q) begin
            first_q <= 1'b0;
          end else if (last_y) begin
            if (last_x) begin
              state_q <= ST_DONE;
            end else begin
              x_q <= x_q + 3'd1;
              y_q <= x_q + 3'd1;
            end
          end else begin
            y_q <= y_q + 3'd1;
          end
        end
        ST_DONE: begin
          if (!res_valid_q || pop_i) begin
            res_valid_q <= 1'b1;
            res_q       <= ok_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_rd_o) begin
      item_q <= q_data_i;
    end
  end

  a_run_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (ok_q && item_q.pre_ok)) else $error("run on failed word");
  a_pair_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (x_q <= y_q && y_q < item_q.n)) else $error("bad deletion set");
  a_fail_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN && !conn) |=> (state_q == ST_DONE && !ok_q))
    else $error("failure not reported");
  a_rd_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_rd_o |=> (state_q != ST_IDLE)) else $error("read word dropped");

endmodule

// ===== rtl/small_graph_three_connectivity_test.sv =====
// ----------------------------------------------------------------------------
// small_graph_three_connectivity_test
// Tests whether a graph of up to seven vertices is 3-vertex-connected.
// ----------------------------------------------------------------------------
// Words are pushed into a two-entry queue after a classifier clamps the
// vertex count, masks the rows and checks that every vertex has at least three
// neighbors. A checker then takes one word at a time and tests reachability
// from the lowest surviving vertex with nothing, each single vertex and each
// pair of vertices removed, one full closure per cycle, stopping at the first
// failure. The checker has a single closure unit; a word that fails the
// degree or size check skips it. The result is held on the output until
// popped, while the next word is already being checked.
module small_graph_three_connectivity_test #(
  parameter int MAX_VERTICES = 7
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [2:0] vertex_count_i,
  input  logic [6:0] adjacency_row_0_i,
  input  logic [6:0] adjacency_row_1_i,
  input  logic [6:0] adjacency_row_2_i,
  input  logic [6:0] adjacency_row_3_i,
  input  logic [6:0] adjacency_row_4_i,
  input  logic [6:0] adjacency_row_5_i,
  input  logic [6:0] adjacency_row_6_i,
  output logic       empty,
  input  logic       pop,
  output logic       is_triconnected_o
);

  sgtc_pkg::row_t [sgtc_pkg::ROW_FIELDS-1:0] rows;
  sgtc_pkg::item_t                           fe_item, q_item;
  logic                                      q_empty, q_rd;

  assign rows[0] = adjacency_row_0_i;
  assign rows[1] = adjacency_row_1_i;
  assign rows[2] = adjacency_row_2_i;
  assign rows[3] = adjacency_row_3_i;
  assign rows[4] = adjacency_row_4_i;
  assign rows[5] = adjacency_row_5_i;
  assign rows[6] = adjacency_row_6_i;

  sgtc_front #(
    .MAX_VERTICES(MAX_VERTICES)
  ) u_front (
    .vertex_count_i(vertex_count_i),
    .rows_i        (rows),
    .item_o        (fe_item)
  );

  sgtc_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (push),
    .wdata_i(fe_item),
    .full_o (full),
    .rd_i   (q_rd),
    .rdata_o(q_item),
    .empty_o(q_empty)
  );

  sgtc_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_empty_i(q_empty),
    .q_data_i (q_item),
    .q_rd_o   (q_rd),
    .empty_o  (empty),
    .pop_i    (pop),
    .res_o    (is_triconnected_o)
  );

endmodule
